FILE: sv/pcomp_pkg.sv
// Shared types, codes and constants of the pixel compositor.
package pcomp_pkg;

    // Largest active size; the user must keep MAX_WIDTH and MAX_HEIGHT at or below this, not enforced here.
    localparam int MAX_DIM_LIMIT = 2048;
    localparam int DIM_W         = $clog2(MAX_DIM_LIMIT) + 1;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 10;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int RGB565_W   = 16;

    localparam logic [SIZE_W-1:0] RST_ACT_WIDTH  = 10'd320;
    localparam logic [SIZE_W-1:0] RST_ACT_HEIGHT = 10'd480;
    localparam logic [CHAN_W-1:0] RST_TINT       = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_FULL      = 8'd255;

    // Channel 2 is red, 1 is green, 0 is blue, so the word packs as R:G:B.
    typedef logic [2:0][CHAN_W-1:0] t_rgb;

    localparam t_rgb KEY_COLOUR = 24'hFF00FF;

    typedef enum logic [1:0] {
        MODE_OPAQUE = 2'd0,
        MODE_BLEND  = 2'd1,
        MODE_GLYPH  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_ACT_WIDTH  = 3'd0,
        REG_ACT_HEIGHT = 3'd1,
        REG_TINT_RED   = 3'd2,
        REG_TINT_GREEN = 3'd3,
        REG_TINT_BLUE  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic [SIZE_W-1:0] act_width;
        logic [SIZE_W-1:0] act_height;
        t_rgb              tint;
    } t_cfg;

endpackage

FILE: sv/pcomp_pixel_ram.sv
// Single-port-write, single-port-read pixel memory with registered read data.
module pcomp_pixel_ram #(
    parameter int DEPTH  = pcomp_pkg::DEF_MAX_WIDTH * pcomp_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  pcomp_pkg::t_rgb            i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output pcomp_pkg::t_rgb            o_rdata
);

    pcomp_pkg::t_rgb mem [DEPTH];
    pcomp_pkg::t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pcomp_cfg_regs.sv
// APB configuration registers: active size and glyph tint.
module pcomp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcomp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pcomp_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pcomp_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output pcomp_pkg::t_cfg                     o_cfg
);

    pcomp_pkg::t_cfg     r_cfg;
    pcomp_pkg::t_reg_idx reg_idx;
    logic                wr_en;

    assign reg_idx = pcomp_pkg::t_reg_idx'(paddr[pcomp_pkg::CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.act_width  <= pcomp_pkg::RST_ACT_WIDTH;
            r_cfg.act_height <= pcomp_pkg::RST_ACT_HEIGHT;
            r_cfg.tint       <= {3{pcomp_pkg::RST_TINT}};
        end else if (wr_en) begin
            unique case (reg_idx)
                pcomp_pkg::REG_ACT_WIDTH:  r_cfg.act_width  <= pwdata[pcomp_pkg::SIZE_W-1:0];
                pcomp_pkg::REG_ACT_HEIGHT: r_cfg.act_height <= pwdata[pcomp_pkg::SIZE_W-1:0];
                pcomp_pkg::REG_TINT_RED:   r_cfg.tint[2]    <= pwdata[pcomp_pkg::CHAN_W-1:0];
                pcomp_pkg::REG_TINT_GREEN: r_cfg.tint[1]    <= pwdata[pcomp_pkg::CHAN_W-1:0];
                pcomp_pkg::REG_TINT_BLUE:  r_cfg.tint[0]    <= pwdata[pcomp_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pcomp_pkg::REG_ACT_WIDTH:  prdata = pcomp_pkg::CFG_DATA_W'(r_cfg.act_width);
            pcomp_pkg::REG_ACT_HEIGHT: prdata = pcomp_pkg::CFG_DATA_W'(r_cfg.act_height);
            pcomp_pkg::REG_TINT_RED:   prdata = pcomp_pkg::CFG_DATA_W'(r_cfg.tint[2]);
            pcomp_pkg::REG_TINT_GREEN: prdata = pcomp_pkg::CFG_DATA_W'(r_cfg.tint[1]);
            pcomp_pkg::REG_TINT_BLUE:  prdata = pcomp_pkg::CFG_DATA_W'(r_cfg.tint[0]);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/pcomp_shade.sv
// Per-channel blend and tint arithmetic: registered products, then divide by 255.
module pcomp_shade (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  pcomp_pkg::t_mode            i_mode,
    input  pcomp_pkg::t_rgb             i_src,
    input  logic [pcomp_pkg::CHAN_W-1:0] i_alpha,
    input  pcomp_pkg::t_rgb             i_dst,
    input  pcomp_pkg::t_rgb             i_tint,
    output pcomp_pkg::t_rgb             o_rgb
);

    localparam int PROD_W = 2 * pcomp_pkg::CHAN_W;

    logic [2:0][PROD_W-1:0] r_p_src;
    logic [2:0][PROD_W-1:0] r_p_dst;
    logic [2:0][PROD_W-1:0] n_p_src;
    logic [2:0][PROD_W-1:0] n_p_dst;
    logic [pcomp_pkg::CHAN_W-1:0] inv_alpha;

    // Exact floor(x/255) for any x up to 255*255.
    function automatic logic [pcomp_pkg::CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W-1:0] t;
        t = x + (x >> pcomp_pkg::CHAN_W) + PROD_W'(1);
        return t[PROD_W-1:pcomp_pkg::CHAN_W];
    endfunction

    assign inv_alpha = pcomp_pkg::CHAN_FULL - i_alpha;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (i_mode)
                pcomp_pkg::MODE_BLEND: begin
                    n_p_src[c] = PROD_W'(i_src[c]) * PROD_W'(i_alpha);
                    n_p_dst[c] = PROD_W'(i_dst[c]) * PROD_W'(inv_alpha);
                end
                default: begin
                    n_p_src[c] = PROD_W'(i_src[c]) * PROD_W'(i_tint[c]);
                    n_p_dst[c] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_src <= n_p_src;
            r_p_dst <= n_p_dst;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_rgb[c] = div255(r_p_src[c] + r_p_dst[c]);
        end
    end

endmodule

FILE: sv/pixel_compositor_backbuffer_top.sv
// Top level of the pixel compositor: command sequencer around the pixel memory.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   tvalid/tready             tuser: mode; tdata: x, y, red, green, blue, alpha
// m_axis    out  tvalid/tready             tuser: off_screen; tdata: pixel_565
// apb       in   psel/penable/pready       active width/height, tint red/green/blue
//
// Every item passes through the steps accept, memory read, product register, and the
// write-back or result load; a new item is accepted only after the last one is done.
// After reset a clearing pass writes black to every entry; no item is accepted during it.
// A readout item waits in its last cycle while the result register is still full.
module pixel_compositor_backbuffer_top #(
    parameter int MAX_WIDTH  = pcomp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pcomp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [10:0] x_pos, [21:11] y_pos, [29:22] red_in, [37:30] green_in,
    // [45:38] blue_in, [53:46] alpha_level, [55:54] zero
    input  logic [55:0]                         s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] pixel_565
    output logic [15:0]                         m_axis_tdata,
    // [0] off_screen
    output logic [0:0]                          m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcomp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pcomp_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pcomp_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = pcomp_pkg::DIM_W;

    pcomp_pkg::t_cfg   cfg;
    pcomp_pkg::t_state r_state;
    pcomp_pkg::t_state n_state;

    logic [ADDR_W-1:0] r_clr_addr;
    logic              clr_last;

    pcomp_pkg::t_mode             r_mode;
    pcomp_pkg::t_rgb              r_src;
    logic [pcomp_pkg::CHAN_W-1:0] r_alpha;
    logic                         r_inside;
    logic [ADDR_W-1:0]            r_addr;

    logic                          r_out_valid;
    logic [pcomp_pkg::RGB565_W-1:0] r_out_pix;
    logic                          r_out_off;

    logic [10:0]       x_pos;
    logic [10:0]       y_pos;
    logic [DIM_W-1:0]  w_lim;
    logic [DIM_W-1:0]  h_lim;
    logic              in_area;
    logic [ADDR_W-1:0] addr;
    logic              in_acc;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    pcomp_pkg::t_rgb   ram_wdata;
    logic              ram_re;
    pcomp_pkg::t_rgb   ram_rdata;
    pcomp_pkg::t_rgb   shade_rgb;
    logic              shade_en;

    logic              out_free;
    logic              is_read;
    logic              item_done;
    logic              out_load;
    logic              keyed;

    pcomp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcomp_pixel_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    pcomp_shade u_shade (
        .i_clk   (i_clk),
        .i_en    (shade_en),
        .i_mode  (r_mode),
        .i_src   (r_src),
        .i_alpha (r_alpha),
        .i_dst   (ram_rdata),
        .i_tint  (cfg.tint),
        .o_rgb   (shade_rgb)
    );

    // Coordinate check and address of the incoming item.
    assign x_pos = s_axis_tdata[10:0];
    assign y_pos = s_axis_tdata[21:11];
    assign w_lim = (DIM_W'(cfg.act_width) > DIM_W'(MAX_WIDTH)) ?
                   DIM_W'(MAX_WIDTH) : DIM_W'(cfg.act_width);
    assign h_lim = (DIM_W'(cfg.act_height) > DIM_W'(MAX_HEIGHT)) ?
                   DIM_W'(MAX_HEIGHT) : DIM_W'(cfg.act_height);
    assign in_area = !x_pos[10] && !y_pos[10] &&
                     (DIM_W'(x_pos[9:0]) < w_lim) && (DIM_W'(y_pos[9:0]) < h_lim);
    assign addr = ADDR_W'(y_pos[9:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_pos[9:0]);

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign out_free = !r_out_valid || m_axis_tready;
    assign is_read  = (r_mode == pcomp_pkg::MODE_READ);
    assign keyed    = (r_mode == pcomp_pkg::MODE_GLYPH) && (r_src == pcomp_pkg::KEY_COLOUR);
    assign item_done = !is_read || out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcomp_pkg::ST_CLEAR: if (clr_last) begin
                n_state = pcomp_pkg::ST_IDLE;
            end
            pcomp_pkg::ST_IDLE: if (in_acc) begin
                n_state = pcomp_pkg::ST_READ;
            end
            pcomp_pkg::ST_READ:  n_state = pcomp_pkg::ST_MUL;
            pcomp_pkg::ST_MUL:   n_state = pcomp_pkg::ST_WRITE;
            pcomp_pkg::ST_WRITE: if (item_done) begin
                n_state = pcomp_pkg::ST_IDLE;
            end
            default: n_state = pcomp_pkg::ST_CLEAR;
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        shade_en      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_addr;
        ram_wdata     = (r_mode == pcomp_pkg::MODE_OPAQUE) ? r_src : shade_rgb;
        out_load      = 1'b0;
        unique case (r_state)
            pcomp_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            pcomp_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            pcomp_pkg::ST_READ:  ram_re = r_inside;
            pcomp_pkg::ST_MUL:   shade_en = 1'b1;
            pcomp_pkg::ST_WRITE: begin
                ram_we   = r_inside && !is_read && !keyed;
                out_load = is_read && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pcomp_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == pcomp_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Red arrives in the lowest source byte and lands in the top channel.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= pcomp_pkg::t_mode'(s_axis_tuser);
            r_src    <= {s_axis_tdata[29:22], s_axis_tdata[37:30], s_axis_tdata[45:38]};
            r_alpha  <= s_axis_tdata[53:46];
            r_inside <= in_area;
            r_addr   <= addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Off-screen readouts give a zero pixel.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_off <= !r_inside;
            r_out_pix <= r_inside ?
                         {ram_rdata[2][7:3], ram_rdata[1][7:2], ram_rdata[0][7:3]} : '0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_pix;
    assign m_axis_tuser[0] = r_out_off;

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("off-screen result carries a nonzero pixel");

    a_rise_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == pcomp_pkg::ST_WRITE))
        else $error("result appeared outside the write-back step");

    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 (r_state == pcomp_pkg::ST_MUL))
        else $error("accepted item did not reach the product step");

    a_write_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != pcomp_pkg::ST_CLEAR) |->
            (r_inside && r_state == pcomp_pkg::ST_WRITE && !is_read))
        else $error("memory write outside the active area or from a readout");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcomp_pkg::ST_CLEAR) |=> (!in_acc || $past(clr_last)))
        else $error("item accepted during the clearing pass");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the pixel compositor with its back buffer and RGB565 readout.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcomp_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Address of an index past the register list; writes there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 5'd28;

    typedef struct {
        logic [RGB565_W-1:0] pixel;
        logic                off;
    } t_readout;

    // Shadow copy of the back buffer and its registers; yields the readouts to expect.
    class backbuffer_shadow;
        bit [PIX_W-1:0]  frame [MAX_W*MAX_H];
        bit [SIZE_W-1:0] width_reg  = RST_ACT_WIDTH;
        bit [SIZE_W-1:0] height_reg = RST_ACT_HEIGHT;
        t_rgb            tint_reg   = {RST_TINT, RST_TINT, RST_TINT};
        t_readout        pending_readouts [$];
        int              errors;

        function void store_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr[1:0] != 2'b00 || addr[CFG_ADDR_W-1:2] > REG_TINT_BLUE)
                return;
            case (t_reg_idx'(addr[CFG_ADDR_W-1:2]))
                REG_ACT_WIDTH:  width_reg  = data[SIZE_W-1:0];
                REG_ACT_HEIGHT: height_reg = data[SIZE_W-1:0];
                REG_TINT_RED:   tint_reg[2] = data[CHAN_W-1:0];
                REG_TINT_GREEN: tint_reg[1] = data[CHAN_W-1:0];
                REG_TINT_BLUE:  tint_reg[0] = data[CHAN_W-1:0];
                default: ;
            endcase
        endfunction

        function void apply_command(t_mode md, logic [10:0] xp, logic [10:0] yp, t_rgb src,
                                    logic [CHAN_W-1:0] alpha);
            int       x, y, w, h, addr;
            bit       in_area;
            t_rgb     cur, nxt;
            t_readout res;
            x = $signed(xp);
            y = $signed(yp);
            w = (width_reg > MAX_W) ? MAX_W : int'(width_reg);
            h = (height_reg > MAX_H) ? MAX_H : int'(height_reg);
            in_area = x >= 0 && y >= 0 && x < w && y < h;
            addr = in_area ? y * MAX_W + x : 0;
            cur = in_area ? frame[addr] : '0;
            if (md == MODE_READ) begin
                res.pixel = in_area ? {cur[2][7:3], cur[1][7:2], cur[0][7:3]} : '0;
                res.off   = !in_area;
                pending_readouts.push_back(res);
                return;
            end
            if (!in_area)
                return;
            case (md)
                MODE_BLEND: begin
                    for (int c = 0; c < 3; c++)
                        nxt[c] = CHAN_W'((int'(src[c]) * int'(alpha)
                                 + int'(cur[c]) * (255 - int'(alpha))) / 255);
                end
                MODE_GLYPH: begin
                    if (src == KEY_COLOUR)
                        return;
                    for (int c = 0; c < 3; c++)
                        nxt[c] = CHAN_W'((int'(src[c]) * int'(tint_reg[c])) / 255);
                end
                default: nxt = src;
            endcase
            frame[addr] = nxt;
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_readout(logic [RGB565_W-1:0] pixel, logic off);
            t_readout want;
            if (pending_readouts.size() == 0) begin
                report_mismatch($sformatf("readout %h off %b with none expected", pixel, off));
                return;
            end
            want = pending_readouts.pop_front();
            if (pixel !== want.pixel)
                report_mismatch($sformatf("pixel_565 %h, expected %h", pixel, want.pixel));
            if (off !== want.off)
                report_mismatch($sformatf("off_screen %b, expected %b", off, want.off));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    backbuffer_shadow shadow;
    bit               calm;
    int               sink_hold;
    int               cycle_count;

    pixel_compositor_backbuffer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check every accepted readout, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_readout(m_axis_tdata, m_axis_tuser[0]);
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow.store_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(int w, int h, int tr, int tg, int tb);
        apb_write({REG_ACT_WIDTH, 2'b00}, w);
        apb_write({REG_ACT_HEIGHT, 2'b00}, h);
        apb_write({REG_TINT_RED, 2'b00}, tr);
        apb_write({REG_TINT_GREEN, 2'b00}, tg);
        apb_write({REG_TINT_BLUE, 2'b00}, tb);
    endtask

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_cmd(t_mode md, logic [10:0] xp, logic [10:0] yp, t_rgb src,
                            logic [CHAN_W-1:0] alpha);
        if (!calm && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= md;
        s_axis_tdata  <= {2'b00, alpha, src[0], src[1], src[2], yp, xp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        shadow.apply_command(md, xp, yp, src, alpha);
    endtask

    // Mostly a small window so that readouts land on written pixels, some near the
    // active edge, the rest anywhere in the 11-bit range.
    function automatic logic [10:0] pick_pos(int eff, int base);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 11'(base + $urandom_range(0, 3));
        if (roll < 85)
            return 11'(eff - 2 + $urandom_range(0, 3));
        return 11'($urandom);
    endfunction

    task automatic run_random(int count);
        int                eff_w, eff_h, base_x, base_y, roll;
        t_mode             md;
        t_rgb              src;
        logic [CHAN_W-1:0] alpha;
        eff_w = (shadow.width_reg > MAX_W) ? MAX_W : int'(shadow.width_reg);
        eff_h = (shadow.height_reg > MAX_H) ? MAX_H : int'(shadow.height_reg);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                base_x = (eff_w > 4) ? $urandom_range(0, eff_w - 4) : 0;
                base_y = (eff_h > 4) ? $urandom_range(0, eff_h - 4) : 0;
            end
            md  = t_mode'($urandom_range(0, 3));
            src = t_rgb'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 10)
                src = KEY_COLOUR;
            else if (roll < 15)
                src = KEY_COLOUR ^ (t_rgb'(1) << $urandom_range(0, PIX_W - 1));
            roll = $urandom_range(0, 99);
            alpha = (roll < 15) ? 8'd0 : (roll < 30) ? CHAN_FULL : CHAN_W'($urandom);
            send_cmd(md, pick_pos(eff_w, base_x), pick_pos(eff_h, base_y), src, alpha);
        end
    endtask

    // Registers change only once the block has gone quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending_readouts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        shadow        = new;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_OPAQUE;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_regs(512, 512, 255, 255, 255);
        apb_write(UNMAPPED_ADDR, 32'h0000_0001);

        send_cmd(MODE_READ,   11'd0,   11'd0,   t_rgb'($urandom), 8'($urandom));
        send_cmd(MODE_OPAQUE, 11'd0,   11'd0,   24'hFFFFFF, 8'd0);
        send_cmd(MODE_READ,   11'd0,   11'd0,   24'h000000, 8'd0);
        // Alpha zero keeps the stored colour, alpha full takes the source.
        send_cmd(MODE_BLEND,  11'd0,   11'd0,   24'h0C2238, 8'd0);
        send_cmd(MODE_READ,   11'd0,   11'd0,   24'h000000, 8'd0);
        send_cmd(MODE_BLEND,  11'd0,   11'd0,   24'h0C2238, CHAN_FULL);
        send_cmd(MODE_READ,   11'd0,   11'd0,   24'h000000, 8'd0);
        send_cmd(MODE_BLEND,  11'd0,   11'd0,   24'hC86432, 8'd128);
        send_cmd(MODE_READ,   11'd0,   11'd0,   24'hFFFFFF, CHAN_FULL);
        send_cmd(MODE_GLYPH,  11'd1,   11'd0,   KEY_COLOUR, 8'd0);
        send_cmd(MODE_READ,   11'd1,   11'd0,   24'h000000, 8'd0);
        send_cmd(MODE_GLYPH,  11'd1,   11'd0,   24'hFF01FF, 8'd0);
        send_cmd(MODE_READ,   11'd1,   11'd0,   24'h000000, 8'd0);
        send_cmd(MODE_OPAQUE, 11'd511, 11'd511, 24'h804020, 8'd0);
        send_cmd(MODE_READ,   11'd511, 11'd511, 24'h000000, 8'd0);
        send_cmd(MODE_OPAQUE, 11'd512, 11'd0,   24'hFFFFFF, 8'd0);
        send_cmd(MODE_READ,   11'd512, 11'd0,   24'h000000, 8'd0);
        send_cmd(MODE_OPAQUE, 11'h7FF, 11'd0,   24'hFFFFFF, 8'd0);
        send_cmd(MODE_READ,   11'h7FF, 11'd0,   24'h000000, 8'd0);
        send_cmd(MODE_READ,   11'h400, 11'h400, 24'h000000, 8'd0);
        send_cmd(MODE_READ,   11'h3FF, 11'h3FF, 24'h000000, 8'd0);
        send_cmd(MODE_OPAQUE, 11'd0,   11'd511, 24'h123456, 8'd0);
        send_cmd(MODE_READ,   11'd0,   11'd511, 24'h000000, 8'd0);
        run_random(120);
        settle();

        set_regs(1, 1, 0, 0, 0);
        run_random(100);
        settle();

        // Sizes above the maximum saturate; the result side holds off long enough
        // for readouts to back up into the input.
        set_regs(1023, 1023, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
        sink_hold = 400;
        run_random(150);
        settle();

        set_regs(0, 300, 255, 0, 128);
        run_random(80);
        settle();

        calm = 1'b1;
        set_regs(17, 9, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
        run_random(175);
        settle();
        calm = 1'b0;

        set_regs($urandom_range(1, 512), $urandom_range(1, 512), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(175);
        settle();

        if (shadow.errors == 0 && shadow.pending_readouts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
